// ----- sv/cqs_pkg.sv -----
// ----------------------------------------------------------------------------
// Circular queue with sort: shared package
// Types, constants and index helpers used by the queue sequencer and its store.
// ----------------------------------------------------------------------------
package cqs_pkg;

  localparam int DEPTH  = 8;
  localparam int DATA_W = 32;
  localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {
    MODE_INSERT = 2'd0,
    MODE_REMOVE = 2'd1,
    MODE_READ   = 2'd2,
    MODE_SORT   = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SORT_RD,
    S_SORT_CMP,
    S_SORT_WB,
    S_READ,
    S_EMIT
  } state_t;

  typedef struct packed {
    mode_t              mode;
    logic signed [31:0] value;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] data;
    status_t            status;
    logic               last;
  } out_word_t;

  // Request from the sequencer to the entry store.
  typedef struct packed {
    logic              we;
    logic [IDX_W-1:0]  waddr;
    logic [DATA_W-1:0] wdata;
    logic              re;
    logic [IDX_W-1:0]  raddr_a;
    logic [IDX_W-1:0]  raddr_b;
  } store_req_t;

  // Physical slot of the entry at queue position pos.
  function automatic logic [IDX_W-1:0] slot_of(input logic [IDX_W-1:0] head,
                                               input logic [IDX_W-1:0] pos);
    logic [IDX_W:0] sum;
    sum = {1'b0, head} + {1'b0, pos};
    if (sum >= (IDX_W+1)'(DEPTH)) begin
      sum = sum - (IDX_W+1)'(DEPTH);
    end
    return sum[IDX_W-1:0];
  endfunction

  function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] idx);
    logic [IDX_W-1:0] res;
    if (idx == IDX_W'(DEPTH - 1)) begin
      res = '0;
    end else begin
      res = idx + IDX_W'(1);
    end
    return res;
  endfunction

endpackage

// ----- sv/cqs_store.sv -----
// ----------------------------------------------------------------------------
// Circular queue entry store
// One write port and two registered read ports over the queue entries.
// ----------------------------------------------------------------------------
module cqs_store
  import cqs_pkg::*;
(
  input  logic              clk,
  input  store_req_t        req,
  output logic [DATA_W-1:0] rd_a,
  output logic [DATA_W-1:0] rd_b
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (req.re) begin
      rd_a <= mem[req.raddr_a];
      rd_b <= mem[req.raddr_b];
    end
  end

endmodule

// ----- sv/cqs_cmp.sv -----
// ----------------------------------------------------------------------------
// Circular queue compare unit
// Signed greater-than compare shared by every step of the sort.
// ----------------------------------------------------------------------------
module cqs_cmp
  import cqs_pkg::*;
(
  input  logic [DATA_W-1:0] a,
  input  logic [DATA_W-1:0] b,
  output logic              gt
);

  assign gt = $signed(a) > $signed(b);

endmodule

// ----- sv/circular_queue_with_sort.sv -----
// ----------------------------------------------------------------------------
// Circular queue with sort: top level
// Insert and remove each leave one result word in the output register.
// Read out goes through a store read, then an emit, for each held entry.
// Sort handles each compared pair with a read, a compare, and a second
// write when the pair is exchanged, through the single store
// write port and the shared compare unit, then reads out as above.
// Reset (synchronous, active low) empties the queue; entries are not cleared.
// ----------------------------------------------------------------------------
module circular_queue_with_sort
  import cqs_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_word_t  in_word,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_word
);

  // Queue pointers and fill level.
  logic [IDX_W-1:0] head_r, head_nxt;
  logic [IDX_W-1:0] tail_r, tail_nxt;
  logic [CNT_W-1:0] fill_r, fill_nxt;

  // Sequencer state and the loop counters of the sort and the read out.
  state_t           state_r, state_nxt;
  logic [IDX_W-1:0] i_r, i_nxt;
  logic [IDX_W-1:0] j_r, j_nxt;
  logic [IDX_W-1:0] k_r, k_nxt;

  // Output register; the input side can move on while the held word drains.
  logic      out_valid_r, out_valid_nxt;
  out_word_t out_word_r, out_word_nxt;

  store_req_t        sreq;
  logic [DATA_W-1:0] rd_a;
  logic [DATA_W-1:0] rd_b;
  logic              gt;

  logic out_free;
  logic in_acc;
  logic j_last;
  logic i_last;
  logic sort_done;
  logic k_last;

  cqs_store u_store (
    .clk  (clk),
    .req  (sreq),
    .rd_a (rd_a),
    .rd_b (rd_b)
  );

  cqs_cmp u_cmp (
    .a  (rd_a),
    .b  (rd_b),
    .gt (gt)
  );

  // The output register can take a new word when it is empty or draining.
  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != S_IDLE) || !out_free;
  assign in_acc   = in_valid && !in_stall;

  // The sort walks pairs (i, j) with i < j over queue positions; the pass
  // ends once the last position has been compared against the one before it.
  assign j_last    = (CNT_W'(j_r) + CNT_W'(1)) == fill_r;
  assign i_last    = (CNT_W'(i_r) + CNT_W'(2)) == fill_r;
  assign sort_done = j_last && i_last;
  assign k_last    = (CNT_W'(k_r) + CNT_W'(1)) == fill_r;

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          case (in_word.mode)
            MODE_READ: begin
              if (fill_r != '0) begin
                state_nxt = S_READ;
              end
            end
            MODE_SORT: begin
              if (fill_r >= CNT_W'(2)) begin
                state_nxt = S_SORT_RD;
              end else if (fill_r != '0) begin
                state_nxt = S_READ;
              end
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_SORT_RD: state_nxt = S_SORT_CMP;
      S_SORT_CMP: begin
        if (gt) begin
          state_nxt = S_SORT_WB;
        end else if (sort_done) begin
          state_nxt = S_READ;
        end else begin
          state_nxt = S_SORT_RD;
        end
      end
      S_SORT_WB: begin
        if (sort_done) begin
          state_nxt = S_READ;
        end else begin
          state_nxt = S_SORT_RD;
        end
      end
      S_READ: state_nxt = S_EMIT;
      S_EMIT: begin
        if (out_free) begin
          state_nxt = k_last ? S_IDLE : S_READ;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Datapath control: store requests, pointer updates, counters and the
  // output register load.
  always_comb begin
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    fill_nxt      = fill_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    k_nxt         = k_r;
    out_word_nxt  = out_word_r;
    out_valid_nxt = out_valid_r;

    sreq.we      = 1'b0;
    sreq.waddr   = tail_r;
    sreq.wdata   = in_word.value;
    sreq.re      = 1'b0;
    sreq.raddr_a = slot_of(head_r, (state_r == S_READ) ? k_r : i_r);
    sreq.raddr_b = slot_of(head_r, j_r);

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          out_valid_nxt       = 1'b1;
          out_word_nxt.data   = '0;
          out_word_nxt.status = ST_OK;
          out_word_nxt.last   = 1'b1;
          k_nxt               = '0;
          i_nxt               = '0;
          j_nxt               = IDX_W'(1);
          case (in_word.mode)
            MODE_INSERT: begin
              if (fill_r == CNT_W'(DEPTH)) begin
                out_word_nxt.status = ST_FULL;
              end else begin
                sreq.we  = 1'b1;
                tail_nxt = wrap_inc(tail_r);
                fill_nxt = fill_r + CNT_W'(1);
              end
            end
            MODE_REMOVE: begin
              if (fill_r == '0) begin
                out_word_nxt.status = ST_EMPTY;
              end else begin
                head_nxt = wrap_inc(head_r);
                fill_nxt = fill_r - CNT_W'(1);
              end
            end
            default: begin
              // Read out and sort give a word here only for an empty queue;
              // otherwise the words come from the emit state.
              if (fill_r == '0) begin
                out_word_nxt.status = ST_EMPTY;
              end else begin
                out_valid_nxt = out_valid_r && out_stall;
                out_word_nxt  = out_word_r;
              end
            end
          endcase
        end
      end
      S_SORT_RD: begin
        sreq.re = 1'b1;
      end
      S_SORT_CMP: begin
        if (gt) begin
          // First half of the exchange: the smaller word moves down.
          sreq.we    = 1'b1;
          sreq.waddr = slot_of(head_r, i_r);
          sreq.wdata = rd_b;
        end else if (j_last) begin
          i_nxt = i_r + IDX_W'(1);
          j_nxt = i_r + IDX_W'(2);
        end else begin
          j_nxt = j_r + IDX_W'(1);
        end
      end
      S_SORT_WB: begin
        sreq.we    = 1'b1;
        sreq.waddr = slot_of(head_r, j_r);
        sreq.wdata = rd_a;
        if (j_last) begin
          i_nxt = i_r + IDX_W'(1);
          j_nxt = i_r + IDX_W'(2);
        end else begin
          j_nxt = j_r + IDX_W'(1);
        end
      end
      S_READ: begin
        sreq.re = 1'b1;
      end
      S_EMIT: begin
        if (out_free) begin
          out_valid_nxt       = 1'b1;
          out_word_nxt.data   = rd_a;
          out_word_nxt.status = ST_OK;
          out_word_nxt.last   = k_last;
          k_nxt               = k_r + IDX_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    i_r        <= i_nxt;
    j_r        <= j_nxt;
    k_r        <= k_nxt;
    out_word_r <= out_word_nxt;
  end

endmodule
